[src/dc16_pkg.sv]
// Package with request types, CRC constants and CRC helper functions.
`timescale 1ns / 1ps
package dc16_pkg;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'h0000;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] ref_crc;
  } in_req_t;

  typedef struct packed {
    logic        match;
    logic [15:0] crc_plain;
    logic [15:0] crc_reflected;
  } out_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ data[7-i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

endpackage

[src/dc16_in_stage.sv]
// Input register that holds one accepted request until the CRC core takes it.
`timescale 1ns / 1ps
module dc16_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dc16_pkg::in_req_t  in_req_i,
  input  logic               take_i,
  output logic               valid_o,
  output dc16_pkg::in_req_t  req_o
);

  logic              valid_q, valid_d;
  dc16_pkg::in_req_t req_q;
  logic              load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

[src/dc16_crc_core.sv]
// Both CRC-16 registers with their byte update, final reflection and compare.
`timescale 1ns / 1ps
module dc16_crc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dc16_pkg::in_req_t  req_i,
  input  logic               out_free_i,
  output logic               take_o,
  output logic               res_valid_o,
  output dc16_pkg::out_req_t res_o
);

  logic [15:0] plain_q, plain_d;
  logic [15:0] refl_q, refl_d;
  logic [15:0] plain_next;
  logic [15:0] refl_next;
  logic [15:0] refl_final;

  assign take_o      = valid_i && (!req_i.last || out_free_i);
  assign res_valid_o = take_o && req_i.last;

  assign plain_next = dc16_pkg::crc_byte(plain_q, req_i.data_byte);
  assign refl_next  = dc16_pkg::crc_byte(refl_q, dc16_pkg::rev8(req_i.data_byte));
  assign refl_final = dc16_pkg::rev16(refl_next);

  always_comb begin
    plain_d = plain_q;
    refl_d  = refl_q;
    if (take_o) begin
      if (req_i.last) begin
        plain_d = dc16_pkg::CrcInit;
        refl_d  = dc16_pkg::CrcInit;
      end else begin
        plain_d = plain_next;
        refl_d  = refl_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q <= dc16_pkg::CrcInit;
      refl_q  <= dc16_pkg::CrcInit;
    end else begin
      plain_q <= plain_d;
      refl_q  <= refl_d;
    end
  end

  assign res_o.match         = (plain_next == req_i.ref_crc) || (refl_final == req_i.ref_crc);
  assign res_o.crc_plain     = plain_next;
  assign res_o.crc_reflected = refl_final;

endmodule

[src/dc16_out_stage.sv]
// Output register that holds a finished result until the receiver takes it.
`timescale 1ns / 1ps
module dc16_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  dc16_pkg::out_req_t res_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dc16_pkg::out_req_t out_req_o
);

  logic               valid_q, valid_d;
  dc16_pkg::out_req_t req_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (out_free_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && res_valid_i) begin
      req_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

endmodule

[src/dual_crc16_block_checker.sv]
// Top level of the dual CRC-16 block checker.
//
//   Channel | Direction | Valid       | Stall       | Request
//   input   | in        | in_valid_i  | in_stall_o  | in_req_i  (data_byte, last, ref_crc)
//   output  | out       | out_valid_o | out_stall_i | out_req_o (match, crc_plain, crc_reflected)
//
// One byte is taken per cycle while no last byte waits on a stalled output; the byte update of
// each CRC register is its own XOR network between the input register and that CRC register.
// A byte marked last has its result written from the input register into the output register.
// Bytes not marked last keep flowing while a result waits on a stalled output.
// A last byte waits in the input register while the output register is full and stalled.
// Reset clears both CRC registers and all valid flags.
`timescale 1ns / 1ps
module dual_crc16_block_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dc16_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dc16_pkg::out_req_t out_req_o
);

  logic               s1_valid;
  dc16_pkg::in_req_t  s1_req;
  logic               take;
  logic               out_free;
  logic               res_valid;
  dc16_pkg::out_req_t res;

  dc16_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .req_o      (s1_req)
  );

  dc16_crc_core u_crc_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .req_i       (s1_req),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dc16_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
